### rtl/core/pitu_pkg.sv
`timescale 1ns / 1ps

package pitu_pkg;

  localparam int unsigned LenW      = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 9;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ArgCntW   = 7;
  localparam int unsigned DelayFlag = 7;

  // Result queue: two slots for the item in flight and two for the one before it.
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;

  typedef enum logic [KindW-1:0] {
    KindWord    = 3'd0,
    KindDelay   = 3'd1,
    KindTrunc   = 3'd2,
    KindNoDelay = 3'd3,
    KindDone    = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PhCmd   = 5'b00001,
    PhCount = 5'b00010,
    PhArgs  = 5'b00100,
    PhDelay = 5'b01000,
    PhDrain = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [WordW-1:0] word;
    logic [ByteW-1:0] ms;
    logic             last;
  } result_t;

  function automatic result_t mk_result(kind_e kind, logic [WordW-1:0] word,
                                        logic [ByteW-1:0] ms, logic last);
    result_t r;
    r.kind = kind;
    r.word = word;
    r.ms   = ms;
    r.last = last;
    return r;
  endfunction

endpackage

### rtl/core/panel_init_table_interpreter_unit.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    seq_byte_i
// out      out_valid_o / out_ready_i  result_kind_o, serial_word_o, pause_ms_o, run_last_o
// cfg      cfg_valid_i / cfg_ready_o  table_length_i
//
// Each table byte is parsed in the cycle it is accepted and yields up to two words,
// which enter a four-entry result queue; a byte is taken whenever two slots are free.
// Throughput is one byte per cycle while the output side takes one word per cycle and
// a byte gives at most one word; bytes that give two words are limited by the output.
// Reset empties the queue and starts a new run; a length write also starts a new run.
`timescale 1ns / 1ps

module panel_init_table_interpreter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pitu_pkg::ByteW-1:0]    seq_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pitu_pkg::KindW-1:0]    result_kind_o,
  output logic [pitu_pkg::WordW-1:0]    serial_word_o,
  output logic [pitu_pkg::ByteW-1:0]    pause_ms_o,
  output logic                          run_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pitu_pkg::LenW-1:0]     table_length_i
);

  pitu_pkg::phase_e                   phase_q, phase_d;
  logic [pitu_pkg::ByteW-1:0]         held_q, held_d;
  logic [pitu_pkg::ArgCntW-1:0]       args_q, args_d;
  logic                               dly_q, dly_d;
  logic [pitu_pkg::LenW-1:0]          pos_q, pos_d;
  logic [pitu_pkg::LenW-1:0]          tlen_q;

  pitu_pkg::result_t                  fifo_q [pitu_pkg::OutDepth];
  logic [pitu_pkg::OutPtrW-1:0]       wr_q, rd_q;
  logic [pitu_pkg::OutCntW-1:0]       count_q;

  logic                               in_fire, out_fire, cfg_fire;
  logic [pitu_pkg::LenW:0]            next_pos, span;
  logic                               last, restart;
  logic [pitu_pkg::ArgCntW-1:0]       cnt;
  logic                               dflag;
  pitu_pkg::result_t                  res0, res1;
  logic [1:0]                         push_n;
  logic [pitu_pkg::OutPtrW-1:0]       wr_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = count_q <= pitu_pkg::OutCntW'(pitu_pkg::OutDepth - 2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = count_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;

  assign result_kind_o = fifo_q[rd_q].kind;
  assign serial_word_o = fifo_q[rd_q].word;
  assign pause_ms_o    = fifo_q[rd_q].ms;
  assign run_last_o    = fifo_q[rd_q].last;

  assign next_pos = {1'b0, pos_q} + (pitu_pkg::LenW+1)'(1);
  assign cnt      = seq_byte_i[pitu_pkg::ArgCntW-1:0];
  assign dflag    = seq_byte_i[pitu_pkg::DelayFlag];
  assign span     = next_pos + (pitu_pkg::LenW+1)'(cnt);
  assign last     = next_pos >= {1'b0, tlen_q};

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    args_d  = args_q;
    dly_d   = dly_q;
    res0    = '0;
    res1    = '0;
    push_n  = 2'd0;
    restart = 1'b0;
    if (tlen_q == '0) begin
      res0    = pitu_pkg::mk_result(pitu_pkg::KindDone, '0, '0, 1'b1);
      push_n  = 2'd1;
      restart = 1'b1;
    end else begin
      unique case (phase_q)
        pitu_pkg::PhCmd: begin
          if (last) begin
            res0    = pitu_pkg::mk_result(pitu_pkg::KindTrunc, '0, '0, 1'b1);
            push_n  = 2'd1;
            restart = 1'b1;
          end else begin
            held_d  = seq_byte_i;
            phase_d = pitu_pkg::PhCount;
          end
        end
        pitu_pkg::PhCount: begin
          if (span > {1'b0, tlen_q}) begin
            res0    = pitu_pkg::mk_result(pitu_pkg::KindTrunc, '0, '0, 1'b1);
            push_n  = 2'd1;
            restart = last;
            phase_d = pitu_pkg::PhDrain;
          end else begin
            res0   = pitu_pkg::mk_result(pitu_pkg::KindWord, {1'b0, held_q}, '0, 1'b0);
            push_n = 2'd1;
            if (cnt != '0) begin
              args_d  = cnt;
              dly_d   = dflag;
              phase_d = pitu_pkg::PhArgs;
            end else if (dflag) begin
              if (last) begin
                res1    = pitu_pkg::mk_result(pitu_pkg::KindNoDelay, '0, '0, 1'b1);
                push_n  = 2'd2;
                restart = 1'b1;
              end else begin
                phase_d = pitu_pkg::PhDelay;
              end
            end else if (last) begin
              res1    = pitu_pkg::mk_result(pitu_pkg::KindDone, '0, '0, 1'b1);
              push_n  = 2'd2;
              restart = 1'b1;
            end else begin
              phase_d = pitu_pkg::PhCmd;
            end
          end
        end
        pitu_pkg::PhArgs: begin
          res0   = pitu_pkg::mk_result(pitu_pkg::KindWord, {1'b1, seq_byte_i}, '0, 1'b0);
          push_n = 2'd1;
          args_d = args_q - pitu_pkg::ArgCntW'(1);
          if (args_d == '0) begin
            if (dly_q) begin
              if (last) begin
                res1    = pitu_pkg::mk_result(pitu_pkg::KindNoDelay, '0, '0, 1'b1);
                push_n  = 2'd2;
                restart = 1'b1;
              end else begin
                phase_d = pitu_pkg::PhDelay;
              end
            end else if (last) begin
              res1    = pitu_pkg::mk_result(pitu_pkg::KindDone, '0, '0, 1'b1);
              push_n  = 2'd2;
              restart = 1'b1;
            end else begin
              phase_d = pitu_pkg::PhCmd;
            end
          end else if (last) begin
            res1    = pitu_pkg::mk_result(pitu_pkg::KindTrunc, '0, '0, 1'b1);
            push_n  = 2'd2;
            restart = 1'b1;
          end
        end
        pitu_pkg::PhDelay: begin
          res0   = pitu_pkg::mk_result(pitu_pkg::KindDelay, '0, seq_byte_i, 1'b0);
          push_n = 2'd1;
          dly_d  = 1'b0;
          if (last) begin
            res1    = pitu_pkg::mk_result(pitu_pkg::KindDone, '0, '0, 1'b1);
            push_n  = 2'd2;
            restart = 1'b1;
          end else begin
            phase_d = pitu_pkg::PhCmd;
          end
        end
        pitu_pkg::PhDrain: begin
          restart = last;
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end
    if (restart) begin
      phase_d = pitu_pkg::PhCmd;
      held_d  = '0;
      args_d  = '0;
      dly_d   = 1'b0;
      pos_d   = '0;
    end else begin
      pos_d   = next_pos[pitu_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pitu_pkg::PhCmd;
      held_q  <= '0;
      args_q  <= '0;
      dly_q   <= 1'b0;
      pos_q   <= '0;
      tlen_q  <= '0;
    end else if (cfg_fire) begin
      phase_q <= pitu_pkg::PhCmd;
      held_q  <= '0;
      args_q  <= '0;
      dly_q   <= 1'b0;
      pos_q   <= '0;
      tlen_q  <= table_length_i;
    end else if (in_fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      args_q  <= args_d;
      dly_q   <= dly_d;
      pos_q   <= pos_d;
    end
  end

  assign wr_inc = wr_q + pitu_pkg::OutPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      fifo_q[wr_q] <= res0;
    end
    if (in_fire && push_n == 2'd2) begin
      fifo_q[wr_inc] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (in_fire) begin
        wr_q <= wr_q + pitu_pkg::OutPtrW'(push_n);
      end
      if (out_fire) begin
        rd_q <= rd_q + pitu_pkg::OutPtrW'(1);
      end
      count_q <= count_q + (in_fire ? pitu_pkg::OutCntW'(push_n) : '0)
                 - pitu_pkg::OutCntW'(out_fire);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pitu_pkg::OutCntW'(pitu_pkg::OutDepth))
    else $error("Result queue holds more words than it has slots.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tlen_q == '0) || (pos_q < tlen_q))
    else $error("Byte position has run past the table length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> (phase_q == pitu_pkg::PhCmd) && (pos_q == '0))
    else $error("A length write did not start a new run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_last_o) |->
      (result_kind_o == pitu_pkg::KindTrunc || result_kind_o == pitu_pkg::KindNoDelay ||
       result_kind_o == pitu_pkg::KindDone))
    else $error("A run ended on a word that is neither done nor an error.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && push_n == 2'd2) |=> count_q >= pitu_pkg::OutCntW'(1))
    else $error("A byte giving two words left the queue empty.");

endmodule
